>>> hdl/crts_pkg.sv
// ----------------------------------------------------------------------------
// crts_pkg
// types, sizes and limits shared by the cell range transition statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package crts_pkg;

    localparam int CELLS      = 262144;
    localparam int FRAMES_MAX = 4096;

    localparam int CELL_AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CELL_REQ_W  = 18;
    localparam int SAMPLE_W    = 8;
    localparam int SAMPLE_SQ_W = 2 * SAMPLE_W;
    localparam int CNT_W       = 13;
    localparam int CHG_W       = 20;
    localparam int CHGSQ_W     = 26;
    localparam int VAL_W       = 20;
    localparam int VALSQ_W     = 27;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SAMPLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = CFG_IDX_W'(1);

    localparam logic [SAMPLE_W-1:0] BAND_LOW_RST  = SAMPLE_W'(15);
    localparam logic [SAMPLE_W-1:0] BAND_HIGH_RST = SAMPLE_W'(128);

    localparam longint SPAN_DEF = longint'(BAND_HIGH_RST) - longint'(BAND_LOW_RST);
    localparam longint TOP_DEF  = longint'(BAND_HIGH_RST);

    localparam longint CNT_LIM_L   = (FRAMES_MAX < 8191) ? FRAMES_MAX : 8191;
    localparam longint CHG_LIM_L   = (FRAMES_MAX * SPAN_DEF < 524287)
                                     ? FRAMES_MAX * SPAN_DEF : 524287;
    localparam longint CHGSQ_LIM_L = (FRAMES_MAX * SPAN_DEF * SPAN_DEF < 67108863)
                                     ? FRAMES_MAX * SPAN_DEF * SPAN_DEF : 67108863;
    localparam longint VAL_LIM_L   = (FRAMES_MAX * TOP_DEF < 1048575)
                                     ? FRAMES_MAX * TOP_DEF : 1048575;
    localparam longint VALSQ_LIM_L = (FRAMES_MAX * TOP_DEF * TOP_DEF < 134217727)
                                     ? FRAMES_MAX * TOP_DEF * TOP_DEF : 134217727;

    localparam logic [CNT_W-1:0]          COUNT_LIMIT = CNT_W'(CNT_LIM_L);
    localparam logic signed [CHG_W:0]     CHG_HI      = (CHG_W+1)'(CHG_LIM_L);
    localparam logic signed [CHG_W:0]     CHG_LO      = -CHG_HI;
    localparam logic [CHGSQ_W-1:0]        CHGSQ_LIMIT = CHGSQ_W'(CHGSQ_LIM_L);
    localparam logic [VAL_W-1:0]          VAL_LIMIT   = VAL_W'(VAL_LIM_L);
    localparam logic [VALSQ_W-1:0]        VALSQ_LIMIT = VALSQ_W'(VALSQ_LIM_L);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PRIME = 2'd0,
        CMD_ACCUM = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low;
        logic [SAMPLE_W-1:0] high;
    } crts_band_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic [CELL_REQ_W-1:0]  cell_idx;
        logic [SAMPLE_W-1:0]    sample;
        logic                   now_in;
        logic [SAMPLE_SQ_W-1:0] sample_sq;
    } crts_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]     prev;
        logic [CNT_W-1:0]        transitions;
        logic [CNT_W-1:0]        retained;
        logic [CNT_W-1:0]        in_band;
        logic signed [CHG_W-1:0] change_total;
        logic [CHGSQ_W-1:0]      change_sq_total;
        logic [VAL_W-1:0]        value_total;
        logic [VALSQ_W-1:0]      value_sq_total;
    } crts_rec_t;

    typedef struct packed {
        logic [CELL_REQ_W-1:0]   cell_idx;
        logic [CNT_W-1:0]        transitions;
        logic [CNT_W-1:0]        retained;
        logic [CNT_W-1:0]        in_band;
        logic signed [CHG_W-1:0] change_sum;
        logic [CHGSQ_W-1:0]      change_sq_sum;
        logic [VAL_W-1:0]        value_sum;
        logic [VALSQ_W-1:0]      value_sq_sum;
    } crts_result_t;

endpackage

`default_nettype wire

>>> hdl/crts_front.sv
// ----------------------------------------------------------------------------
// crts_front
// band registers, item acceptance and classification ahead of the queue
// ----------------------------------------------------------------------------
`default_nettype none

module crts_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [crts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crts_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                start,
    input  logic [1:0]                          command,
    input  logic [crts_pkg::CELL_REQ_W-1:0]     cell_req,
    input  logic [crts_pkg::SAMPLE_W-1:0]       sample,
    input  logic                                stall,
    output logic                                busy,
    output logic                                push,
    output crts_pkg::crts_item_t                push_item,
    output crts_pkg::crts_band_t                band
);

    import crts_pkg::*;

    logic [SAMPLE_W-1:0] band_low_reg;
    logic [SAMPLE_W-1:0] band_high_reg;
    logic                accept;
    logic                cell_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_low_reg  <= BAND_LOW_RST;
            band_high_reg <= BAND_HIGH_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BAND_LOW:  band_low_reg  <= cfg_data;
                REG_BAND_HIGH: band_high_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign busy    = stall;
    assign accept  = start && !stall;
    assign cell_ok = (32'(cell_req) < 32'(CELLS));
    assign push    = accept && cell_ok;

    always_comb
    begin
        push_item.cmd       = cmd_t'(command);
        push_item.cell_idx  = cell_req;
        push_item.sample    = sample;
        push_item.now_in    = (sample >= band_low_reg) && (sample <= band_high_reg);
        push_item.sample_sq = SAMPLE_SQ_W'(sample * sample);
    end

    assign band.low  = band_low_reg;
    assign band.high = band_high_reg;

endmodule

`default_nettype wire

>>> hdl/crts_queue.sv
// ----------------------------------------------------------------------------
// crts_queue
// short first-in first-out queue of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module crts_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  crts_pkg::crts_item_t  push_item,
    input  logic                  pop,
    output logic                  head_valid,
    output crts_pkg::crts_item_t  head_item,
    output logic                  full
);

    import crts_pkg::*;

    crts_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic                do_push;
    logic                do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_item  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    assign wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_next;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_next;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // front must hold off while the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("item pushed into full queue");

endmodule

`default_nettype wire

>>> hdl/crts_back.sv
// ----------------------------------------------------------------------------
// crts_back
// per-cell statistics memory, read-modify-write pipeline and result register
// ----------------------------------------------------------------------------
`default_nettype none

module crts_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crts_pkg::crts_band_t   band,
    input  logic                   head_valid,
    input  crts_pkg::crts_item_t   head_item,
    output logic                   pop,
    output logic                   clearing,
    output logic                   done,
    output crts_pkg::crts_result_t result
);

    import crts_pkg::*;

    crts_rec_t           stat_mem [CELLS];
    crts_rec_t           rd_rec_reg;
    logic                clr_active_reg;
    logic [CELL_AW-1:0]  clr_addr_reg;
    logic                b_valid_reg;
    crts_item_t          b_item_reg;
    logic                wb_valid_reg;
    logic [CELL_AW-1:0]  wb_addr_reg;
    crts_rec_t           wb_rec_reg;
    logic                done_reg;
    crts_result_t        res_reg;

    logic [CELL_AW-1:0]  head_addr;
    logic [CELL_AW-1:0]  b_addr;
    crts_rec_t           rec_cur;
    crts_rec_t           rec_next;
    logic                b_write;
    logic                mem_we;
    logic [CELL_AW-1:0]  mem_waddr;
    crts_rec_t           mem_wdata;

    logic                was_in;
    logic                now_in;
    logic signed [SAMPLE_W:0]   diff;
    logic [SAMPLE_W-1:0]        diff_abs;
    logic [SAMPLE_SQ_W-1:0]     diff_sq;
    logic signed [CHG_W:0]      chg_sum;
    logic [CHGSQ_W:0]           chgsq_sum;
    logic [VAL_W:0]             val_sum;
    logic [VALSQ_W:0]           valsq_sum;

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
        return (c < COUNT_LIMIT) ? c + 1'b1 : COUNT_LIMIT;
    endfunction

    assign pop       = head_valid && !clr_active_reg;
    assign clearing  = clr_active_reg;
    assign head_addr = CELL_AW'(head_item.cell_idx);
    assign b_addr    = CELL_AW'(b_item_reg.cell_idx);
    assign b_write   = b_valid_reg && (b_item_reg.cmd != CMD_READ);

    // the item ahead wrote on the edge this one was read
    assign rec_cur = (wb_valid_reg && (wb_addr_reg == b_addr)) ? wb_rec_reg : rd_rec_reg;

    always_comb
    begin
        now_in    = b_item_reg.now_in;
        was_in    = (rec_cur.prev >= band.low) && (rec_cur.prev <= band.high);
        diff      = $signed({1'b0, b_item_reg.sample}) - $signed({1'b0, rec_cur.prev});
        diff_abs  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
        diff_sq   = SAMPLE_SQ_W'(diff_abs * diff_abs);
        chg_sum   = {rec_cur.change_total[CHG_W-1], rec_cur.change_total}
                    + {{(CHG_W-SAMPLE_W){diff[SAMPLE_W]}}, diff};
        chgsq_sum = {1'b0, rec_cur.change_sq_total} + (CHGSQ_W+1)'(diff_sq);
        val_sum   = {1'b0, rec_cur.value_total} + (VAL_W+1)'(b_item_reg.sample);
        valsq_sum = {1'b0, rec_cur.value_sq_total} + (VALSQ_W+1)'(b_item_reg.sample_sq);

        rec_next = rec_cur;
        case (b_item_reg.cmd)
            CMD_PRIME:
            begin
                rec_next.prev = b_item_reg.sample;
            end
            CMD_ACCUM:
            begin
                if (now_in != was_in)
                    rec_next.transitions = count_up(rec_cur.transitions);
                if (now_in && was_in)
                begin
                    if (chg_sum > CHG_HI)
                        rec_next.change_total = CHG_HI[CHG_W-1:0];
                    else if (chg_sum < CHG_LO)
                        rec_next.change_total = CHG_LO[CHG_W-1:0];
                    else
                        rec_next.change_total = chg_sum[CHG_W-1:0];
                    rec_next.change_sq_total = (chgsq_sum > {1'b0, CHGSQ_LIMIT})
                                               ? CHGSQ_LIMIT : chgsq_sum[CHGSQ_W-1:0];
                    rec_next.value_total     = (val_sum > {1'b0, VAL_LIMIT})
                                               ? VAL_LIMIT : val_sum[VAL_W-1:0];
                    rec_next.value_sq_total  = (valsq_sum > {1'b0, VALSQ_LIMIT})
                                               ? VALSQ_LIMIT : valsq_sum[VALSQ_W-1:0];
                    rec_next.retained        = count_up(rec_cur.retained);
                end
                if (now_in)
                    rec_next.in_band = count_up(rec_cur.in_band);
                rec_next.prev = b_item_reg.sample;
            end
            CMD_CLEAR:
            begin
                rec_next      = '0;
                rec_next.prev = rec_cur.prev;
            end
            default:
            begin
                rec_next = rec_cur;
            end
        endcase
    end

    assign mem_we    = clr_active_reg || b_write;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : b_addr;
    assign mem_wdata = clr_active_reg ? '0 : rec_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stat_mem[mem_waddr] <= mem_wdata;
        if (pop)
            rd_rec_reg <= stat_mem[head_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            b_valid_reg    <= 1'b0;
            wb_valid_reg   <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == CELL_AW'(CELLS - 1))
                    clr_active_reg <= 1'b0;
            end
            b_valid_reg  <= pop;
            wb_valid_reg <= b_write;
            done_reg     <= b_valid_reg && (b_item_reg.cmd == CMD_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            b_item_reg <= head_item;
        wb_addr_reg <= b_addr;
        wb_rec_reg  <= rec_next;
        res_reg.cell_idx      <= b_item_reg.cell_idx;
        res_reg.transitions   <= rec_cur.transitions;
        res_reg.retained      <= rec_cur.retained;
        res_reg.in_band       <= rec_cur.in_band;
        res_reg.change_sum    <= rec_cur.change_total;
        res_reg.change_sq_sum <= rec_cur.change_sq_total;
        res_reg.value_sum     <= rec_cur.value_total;
        res_reg.value_sq_sum  <= rec_cur.value_sq_total;
    end

    assign done   = done_reg;
    assign result = res_reg;

    // no item runs while the memory is being cleared
    a_idle_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!b_valid_reg && !pop))
        else $error("item in flight during memory clear");

    // a result only follows a read in the compute stage
    a_done_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && (b_item_reg.cmd == CMD_READ) |=> done_reg)
        else $error("read item gave no result");

    a_done_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && (b_item_reg.cmd != CMD_READ) |=> !done_reg)
        else $error("result from a non-read item");

endmodule

`default_nettype wire

>>> hdl/cell_range_transition_statistics.sv
// ----------------------------------------------------------------------------
// cell_range_transition_statistics
// per-cell band transition counts and in-band sums over a stream of samples
// ----------------------------------------------------------------------------
// One item per clock: an item is taken on an edge with start high and busy
// low; a read item passes a queue slot, the memory read and item registers
// and the result register, and comes out with done high for one cycle; results
// cannot be held off. The rate is set by the read-modify-write of the per-cell
// statistics memory, read at one entry and written at another each cycle, with
// the last written entry bypassed to the next item.
// After reset busy stays high while the memory is cleared one entry per cycle,
// all CELLS (262144) entries; the user must write band registers only while
// no item is in flight, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_range_transition_statistics (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [crts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [crts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           command,
    input  logic [crts_pkg::CELL_REQ_W-1:0]      cell_req,
    input  logic [crts_pkg::SAMPLE_W-1:0]        sample,
    output logic                                 done,
    output logic [crts_pkg::CELL_REQ_W-1:0]      cell_out,
    output logic [crts_pkg::CNT_W-1:0]           transitions,
    output logic [crts_pkg::CNT_W-1:0]           retained_frames,
    output logic [crts_pkg::CNT_W-1:0]           in_band_frames,
    output logic signed [crts_pkg::CHG_W-1:0]    change_sum,
    output logic [crts_pkg::CHGSQ_W-1:0]         change_square_sum,
    output logic [crts_pkg::VAL_W-1:0]           value_sum,
    output logic [crts_pkg::VALSQ_W-1:0]         value_square_sum
);

    import crts_pkg::*;

    logic         push;
    crts_item_t   push_item;
    crts_band_t   band;
    logic         pop;
    logic         head_valid;
    crts_item_t   head_item;
    logic         queue_full;
    logic         clearing;
    crts_result_t result;

    crts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .command   (command),
        .cell_req  (cell_req),
        .sample    (sample),
        .stall     (queue_full || clearing),
        .busy      (busy),
        .push      (push),
        .push_item (push_item),
        .band      (band)
    );

    crts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .full       (queue_full)
    );

    crts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .band       (band),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .result     (result)
    );

    assign cell_out          = result.cell_idx;
    assign transitions       = result.transitions;
    assign retained_frames   = result.retained;
    assign in_band_frames    = result.in_band;
    assign change_sum        = result.change_sum;
    assign change_square_sum = result.change_sq_sum;
    assign value_sum         = result.value_sum;
    assign value_square_sum  = result.value_sq_sum;

endmodule

`default_nettype wire
